FILE: sv/pewq_pkg.sv
package pewq_pkg;

    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 16;
    localparam int KIND_W      = 2;
    localparam int TIME_W      = 32;
    localparam int DEV_ID_W    = 6;
    localparam int TASK_ID_W   = 5;
    localparam int PRIO_W      = 6;
    localparam int MAX_TASKS   = 32;

    localparam logic [TIME_W-1:0] LAST_PERIOD = 32'd9000;

    localparam logic [KIND_W-1:0] KIND_INIT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WAIT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

    typedef struct packed {
        logic                 push;
        logic                 flush;
        logic [TASK_ID_W-1:0] task_id;
        logic [PRIO_W-1:0]    prio;
    } out_ctl_t;

    typedef struct packed {
        logic room;
        logic pend;
    } out_sts_t;

endpackage

FILE: sv/pewq_out_stage.sv
module pewq_out_stage
    import pewq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  out_ctl_t             ctl,
    output out_sts_t             sts,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // woken_task, woken_priority
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic                 pend_valid_reg;
    logic [TASK_ID_W-1:0] pend_task_reg;
    logic [PRIO_W-1:0]    pend_prio_reg;
    logic                 out_valid_reg;
    logic [TASK_ID_W-1:0] out_task_reg;
    logic [PRIO_W-1:0]    out_prio_reg;
    logic                 out_last_reg;
    logic                 out_free;
    logic                 emit;

    assign out_free = !out_valid_reg || m_tready;
    assign emit     = out_free && pend_valid_reg && (ctl.push || ctl.flush);
    assign sts.room = !pend_valid_reg || out_free;
    assign sts.pend = pend_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (ctl.push && sts.room) begin
                pend_valid_reg <= 1'b1;
            end else if (ctl.flush && sts.room) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_task_reg <= pend_task_reg;
            out_prio_reg <= pend_prio_reg;
            out_last_reg <= ctl.flush;
        end
        if (ctl.push && sts.room) begin
            pend_task_reg <= ctl.task_id;
            pend_prio_reg <= ctl.prio;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - TASK_ID_W - PRIO_W){1'b0}}, out_prio_reg, out_task_reg};
    assign m_tlast  = out_last_reg;

endmodule

FILE: sv/periodic_event_wait_queues_unit.sv
// periodic event wait queues
// input channel s_*: one item per handshake; s_tuser carries the kind
// (init, wait, tick), s_tdata carries time, device, task and priority
// output channel m_*: one item per woken task, m_tlast marks the final wake
// of a tick; a tick that wakes nothing sends no item
// init and an ignored wait finish in idle; a wait writes the device record, then
// links the old tail's task record if its queue was not empty; a tick reads one
// device record per cycle from the device memory, one task record per cycle from
// the task memory while the output has room; a wake leaves after one further wake
// or the end of the scan, since the last flag is only known then
// the output register and a pending stage let the next item be accepted
// while the final wake still waits on m_tready; a stalled receiver holds
// the scan at the next wake
// reset empties all queues and sets each match time to its period through
// valid bits, so no clearing pass is needed and the block is ready at once
module periodic_event_wait_queues_unit
    import pewq_pkg::*;
#(
    parameter int DEVICE_COUNT = 60,
    parameter int TASK_COUNT   = 32,
    parameter int PERIOD_STEP  = 100
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // now_ms, device, task_req, priority_req
    input  logic [S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [KIND_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // woken_task, woken_priority
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int TASK_DEPTH = (TASK_COUNT < MAX_TASKS) ? TASK_COUNT : MAX_TASKS;
    localparam int TI         = $clog2(TASK_DEPTH);
    localparam int DI         = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
    localparam int DEV_W      = TIME_W + 2 * TI;
    localparam int TASK_W     = TI + PRIO_W;
    localparam logic [DI-1:0] LAST_DEV = DI'(DEVICE_COUNT - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WDEV = 3'd1;
    localparam logic [2:0] ST_WTSK = 3'd2;
    localparam logic [2:0] ST_TEV  = 3'd3;
    localparam logic [2:0] ST_TWK  = 3'd4;
    localparam logic [2:0] ST_TEND = 3'd5;

    logic [DEV_W-1:0]  dev_mem [DEVICE_COUNT];
    logic [TASK_W-1:0] task_mem [TASK_DEPTH];

    logic [2:0]              state_reg, state_next;
    logic [DI-1:0]           d_reg, d_next;
    logic [TIME_W-1:0]       per_reg, per_next;
    logic [TIME_W-1:0]       base_reg, base_next;
    logic [TIME_W-1:0]       now_reg, now_next;
    logic [TI-1:0]           wtask_reg, wtask_next;
    logic [TI-1:0]           cur_reg, cur_next;
    logic [TI-1:0]           tail_reg, tail_next;
    logic [DEVICE_COUNT-1:0] match_valid_reg, match_valid_next;
    logic [DEVICE_COUNT-1:0] head_valid_reg, head_valid_next;
    logic [TASK_DEPTH-1:0]   queued_reg, queued_next;

    logic [DEV_W-1:0]  dev_rdata_reg;
    logic [TASK_W-1:0] task_rdata_reg;
    logic              dev_we;
    logic [DI-1:0]     dev_waddr, dev_raddr;
    logic [DEV_W-1:0]  dev_wdata;
    logic              task_we;
    logic [TI-1:0]     task_waddr, task_raddr;
    logic [TASK_W-1:0] task_wdata;

    logic [KIND_W-1:0]    in_kind;
    logic [TIME_W-1:0]    in_now;
    logic [DEV_ID_W-1:0]  in_dev;
    logic [TASK_ID_W-1:0] in_task;
    logic [PRIO_W-1:0]    in_prio;
    logic                 s_acc;
    logic                 wait_ok;

    logic [TIME_W-1:0] rd_match;
    logic [TI-1:0]     rd_head, rd_tail;
    logic [TI-1:0]     t_next;
    logic [PRIO_W-1:0] t_prio;
    logic [TIME_W-1:0] per_eff, eff_match, new_match;
    logic              due, d_last;
    logic [DI-1:0]     d_inc;

    out_ctl_t out_ctl;
    out_sts_t out_sts;

    assign in_kind = s_tuser;
    assign in_now  = s_tdata[31:0];
    assign in_dev  = s_tdata[37:32];
    assign in_task = s_tdata[42:38];
    assign in_prio = s_tdata[48:43];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign wait_ok  = (7'(in_dev) < 7'(DEVICE_COUNT)) && (7'(in_task) < 7'(TASK_COUNT))
                      && !queued_reg[in_task[TI-1:0]];

    assign rd_match = dev_rdata_reg[DEV_W-1 -: TIME_W];
    assign rd_head  = dev_rdata_reg[2*TI-1:TI];
    assign rd_tail  = dev_rdata_reg[TI-1:0];
    assign t_next   = task_rdata_reg[TASK_W-1:PRIO_W];
    assign t_prio   = task_rdata_reg[PRIO_W-1:0];

    assign d_last    = (d_reg == LAST_DEV);
    assign d_inc     = d_last ? d_reg : d_reg + DI'(1);
    assign per_eff   = d_last ? LAST_PERIOD : per_reg;
    assign eff_match = match_valid_reg[d_reg] ? rd_match : per_eff + base_reg;
    assign new_match = eff_match + per_eff;
    assign due       = (now_reg >= eff_match);

    always_comb begin
        state_next       = state_reg;
        d_next           = d_reg;
        per_next         = per_reg;
        base_next        = base_reg;
        now_next         = now_reg;
        wtask_next       = wtask_reg;
        cur_next         = cur_reg;
        tail_next        = tail_reg;
        match_valid_next = match_valid_reg;
        head_valid_next  = head_valid_reg;
        queued_next      = queued_reg;
        dev_we           = 1'b0;
        dev_waddr        = d_reg;
        dev_wdata        = {eff_match, rd_head, rd_tail};
        dev_raddr        = d_reg;
        task_we          = 1'b0;
        task_waddr       = tail_reg;
        task_wdata       = {wtask_reg, t_prio};
        task_raddr       = cur_reg;
        out_ctl          = '0;

        case (state_reg)
            ST_IDLE: begin
                dev_raddr = (in_kind == KIND_TICK) ? '0 : in_dev[DI-1:0];
                if (s_acc) begin
                    case (in_kind)
                        KIND_INIT: begin
                            base_next        = in_now;
                            match_valid_next = '0;
                            head_valid_next  = '0;
                            queued_next      = '0;
                        end
                        KIND_WAIT: begin
                            if (wait_ok) begin
                                queued_next[in_task[TI-1:0]] = 1'b1;
                                d_next     = in_dev[DI-1:0];
                                wtask_next = in_task[TI-1:0];
                                per_next   = 32'(PERIOD_STEP) * (32'(in_dev) + 32'd1);
                                task_we    = 1'b1;
                                task_waddr = in_task[TI-1:0];
                                task_wdata = {TI'(0), in_prio};
                                state_next = ST_WDEV;
                            end
                        end
                        KIND_TICK: begin
                            now_next   = in_now;
                            d_next     = '0;
                            per_next   = 32'(PERIOD_STEP);
                            state_next = ST_TEV;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WDEV: begin
                dev_we = 1'b1;
                match_valid_next[d_reg] = 1'b1;
                if (head_valid_reg[d_reg]) begin
                    dev_wdata  = {eff_match, rd_head, wtask_reg};
                    task_raddr = rd_tail;
                    tail_next  = rd_tail;
                    state_next = ST_WTSK;
                end else begin
                    dev_wdata  = {eff_match, wtask_reg, wtask_reg};
                    head_valid_next[d_reg] = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_WTSK: begin
                task_we    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_TEV: begin
                if (due) begin
                    dev_we    = 1'b1;
                    dev_wdata = {new_match, rd_head, rd_tail};
                    match_valid_next[d_reg] = 1'b1;
                end
                if (due && head_valid_reg[d_reg]) begin
                    head_valid_next[d_reg] = 1'b0;
                    cur_next   = rd_head;
                    tail_next  = rd_tail;
                    task_raddr = rd_head;
                    state_next = ST_TWK;
                end else if (d_last) begin
                    state_next = ST_TEND;
                end else begin
                    d_next    = d_inc;
                    per_next  = per_reg + 32'(PERIOD_STEP);
                    dev_raddr = d_inc;
                end
            end
            ST_TWK: begin
                dev_raddr = d_inc;
                if (out_sts.room) begin
                    out_ctl.push    = 1'b1;
                    out_ctl.task_id = TASK_ID_W'(cur_reg);
                    out_ctl.prio    = t_prio;
                    queued_next[cur_reg] = 1'b0;
                    if (cur_reg == tail_reg) begin
                        if (d_last) begin
                            state_next = ST_TEND;
                        end else begin
                            d_next     = d_inc;
                            per_next   = per_reg + 32'(PERIOD_STEP);
                            state_next = ST_TEV;
                        end
                    end else begin
                        cur_next   = t_next;
                        task_raddr = t_next;
                    end
                end
            end
            ST_TEND: begin
                out_ctl.flush = 1'b1;
                if (out_sts.room) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            base_reg        <= '0;
            match_valid_reg <= '0;
            head_valid_reg  <= '0;
            queued_reg      <= '0;
        end else begin
            state_reg       <= state_next;
            base_reg        <= base_next;
            match_valid_reg <= match_valid_next;
            head_valid_reg  <= head_valid_next;
            queued_reg      <= queued_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg     <= d_next;
        per_reg   <= per_next;
        now_reg   <= now_next;
        wtask_reg <= wtask_next;
        cur_reg   <= cur_next;
        tail_reg  <= tail_next;
    end

    always_ff @(posedge aclk) begin
        if (dev_we) begin
            dev_mem[dev_waddr] <= dev_wdata;
        end
        dev_rdata_reg <= dev_mem[dev_raddr];
    end

    always_ff @(posedge aclk) begin
        if (task_we) begin
            task_mem[task_waddr] <= task_wdata;
        end
        task_rdata_reg <= task_mem[task_raddr];
    end

    pewq_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (out_ctl),
        .sts      (out_sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_walk_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TWK) |-> queued_reg[cur_reg])
        else $error("walked task is not marked queued");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TEV || state_reg == ST_TWK) |-> (7'(d_reg) < 7'(DEVICE_COUNT)))
        else $error("scan device index out of range");

    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !out_sts.pend)
        else $error("pending wake left behind after tick");

endmodule

FILE: tb/sv/tb.sv
module tb;
    import pewq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEV_N  = 60;
    localparam int TASK_N = MAX_TASKS;
    localparam int STEP   = 100;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct {
        logic [TASK_ID_W-1:0] task_id;
        logic [PRIO_W-1:0]    prio;
        logic                 last;
    } wake_t;

    class wake_scoreboard;
        logic [TIME_W-1:0]    match_time [DEV_N];
        logic [TASK_ID_W-1:0] head       [DEV_N];
        bit                   head_valid [DEV_N];
        logic [TASK_ID_W-1:0] tail       [DEV_N];
        logic [TASK_ID_W-1:0] next_task  [TASK_N];
        logic [PRIO_W-1:0]    task_prio  [TASK_N];
        bit                   queued     [TASK_N];
        wake_t                wakes_due  [$];
        int                   errors;
        int                   wakes_predicted;

        function new();
            errors = 0;
            wakes_predicted = 0;
            clear_queues();
            for (int d = 0; d < DEV_N; d++) begin
                match_time[d] = period_of(d);
            end
        endfunction

        function logic [TIME_W-1:0] period_of(int d);
            if (d == DEV_N - 1) begin
                return LAST_PERIOD;
            end
            return TIME_W'(STEP * (d + 1));
        endfunction

        function void clear_queues();
            for (int d = 0; d < DEV_N; d++) begin
                head[d] = '0;
                head_valid[d] = 1'b0;
                tail[d] = '0;
            end
            for (int t = 0; t < TASK_N; t++) begin
                next_task[t] = '0;
                task_prio[t] = '0;
                queued[t] = 1'b0;
            end
        endfunction

        function int pending();
            return wakes_due.size();
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [S_TDATA_W-1:0] data);
            logic [TIME_W-1:0]    now;
            logic [DEV_ID_W-1:0]  dev;
            logic [TASK_ID_W-1:0] tid;
            logic [PRIO_W-1:0]    pr;
            logic [TASK_ID_W-1:0] cur;
            bit                   at_tail;
            int                   n;
            int                   guard;
            wake_t                w;
            now = data[31:0];
            dev = data[37:32];
            tid = data[42:38];
            pr  = data[48:43];
            n = 0;
            case (kind)
                KIND_INIT: begin
                    clear_queues();
                    for (int d = 0; d < DEV_N; d++) begin
                        match_time[d] = period_of(d) + now;
                    end
                end
                KIND_WAIT: begin
                    if (dev < DEV_N && tid < TASK_N && !queued[tid]) begin
                        queued[tid] = 1'b1;
                        task_prio[tid] = pr;
                        next_task[tid] = '0;
                        if (!head_valid[dev]) begin
                            head_valid[dev] = 1'b1;
                            head[dev] = tid;
                        end else begin
                            next_task[tail[dev]] = tid;
                        end
                        tail[dev] = tid;
                    end
                end
                KIND_TICK: begin
                    for (int d = 0; d < DEV_N; d++) begin
                        if (now < match_time[d]) continue;
                        match_time[d] = match_time[d] + period_of(d);
                        if (!head_valid[d]) continue;
                        cur = head[d];
                        for (guard = 0; guard < MAX_TASKS; guard++) begin
                            at_tail = (cur == tail[d]);
                            w.task_id = cur;
                            w.prio = task_prio[cur];
                            w.last = 1'b0;
                            wakes_due.push_back(w);
                            n++;
                            queued[cur] = 1'b0;
                            if (at_tail) break;
                            cur = next_task[cur];
                        end
                        head_valid[d] = 1'b0;
                        head[d] = '0;
                    end
                    if (n > 0) begin
                        wakes_due[wakes_due.size() - 1].last = 1'b1;
                    end
                    wakes_predicted += n;
                end
                default: ;
            endcase
        endfunction

        function void check_wake(logic [TASK_ID_W-1:0] tid, logic [PRIO_W-1:0] pr,
                                 logic last);
            wake_t w;
            if (wakes_due.size() == 0) begin
                $display("%0t: unexpected wake task %0d prio %0d last %0b",
                         $time, tid, pr, last);
                errors++;
                return;
            end
            w = wakes_due.pop_front();
            if (tid !== w.task_id) begin
                $display("%0t: woken_task expected %0d actual %0d", $time, w.task_id, tid);
                errors++;
            end
            if (pr !== w.prio) begin
                $display("%0t: woken_priority expected %0d actual %0d", $time, w.prio, pr);
                errors++;
            end
            if (last !== w.last) begin
                $display("%0t: last expected %0b actual %0b", $time, w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    int src_idle_pct  = 30;
    int sink_idle_pct = 58;

    wake_scoreboard sb = new();

    periodic_event_wait_queues_unit #(
        .DEVICE_COUNT(DEV_N),
        .TASK_COUNT  (TASK_N),
        .PERIOD_STEP (STEP)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_wake(m_tdata[4:0], m_tdata[10:5], m_tlast);
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now,
                             input logic [DEV_ID_W-1:0] dev,
                             input logic [TASK_ID_W-1:0] tid,
                             input logic [PRIO_W-1:0] pr);
        logic [S_TDATA_W-1:0] data;
        data = {7'b0, pr, tid, dev, now};
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(kind, data);
    endtask

    // hold off the sender until every predicted wake has been seen
    task automatic drain_wakes();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        logic [TIME_W-1:0] clock_ms;
        int                sel;
        int                i;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(KIND_SPARE, '1, '1, '1, '1);
        send_item(KIND_WAIT, 32'd0, 6'd0, 5'd0, 6'd0);
        send_item(KIND_WAIT, '1, 6'd59, 5'd31, 6'd63);
        send_item(KIND_WAIT, 32'd0, 6'd63, 5'd5, 6'd9);
        send_item(KIND_WAIT, 32'd0, 6'd60, 5'd6, 6'd9);
        send_item(KIND_WAIT, 32'd0, 6'd0, 5'd0, 6'd7);
        send_item(KIND_WAIT, 32'd0, 6'd0, 5'd1, 6'd21);
        send_item(KIND_WAIT, 32'd0, 6'd0, 5'd2, 6'd42);
        send_item(KIND_WAIT, 32'd0, 6'd1, 5'd3, 6'd1);
        send_item(KIND_TICK, 32'd99, 6'd0, 5'd0, 6'd0);
        send_item(KIND_TICK, 32'd100, 6'd0, 5'd0, 6'd0);
        send_item(KIND_TICK, 32'd200, 6'd0, 5'd0, 6'd0);
        send_item(KIND_TICK, '1, 6'd0, 5'd0, 6'd0);
        send_item(KIND_INIT, '1, '1, '1, '1);
        send_item(KIND_WAIT, 32'd0, 6'd2, 5'd4, 6'd50);
        send_item(KIND_TICK, 32'd298, 6'd0, 5'd0, 6'd0);
        send_item(KIND_TICK, 32'd299, 6'd0, 5'd0, 6'd0);
        send_item(KIND_WAIT, 32'd0, 6'd5, 5'd9, 6'd11);
        send_item(KIND_INIT, 32'd0, 6'd0, 5'd0, 6'd0);
        send_item(KIND_WAIT, 32'd0, 6'd5, 5'd9, 6'd12);
        send_item(KIND_WAIT, 32'd0, 6'd5, 5'd10, 6'd13);
        send_item(KIND_TICK, 32'd600, 6'd0, 5'd0, 6'd0);
        send_item(KIND_TICK, 32'd1200, 6'd0, 5'd0, 6'd0);
        drain_wakes();

        clock_ms = 32'd1200;
        i = 0;
        while (i < 200) begin
            if (i == 67) begin
                src_idle_pct  = 58;
                sink_idle_pct = 30;
            end else if (i == 134) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (i == 100) drain_wakes();
            sel = $urandom_range(99);
            if (sel < 50) begin
                send_item(KIND_WAIT, $urandom(), 6'($urandom_range(15)),
                          5'($urandom_range(31)), 6'($urandom_range(63)));
            end else if (sel < 58) begin
                send_item(KIND_WAIT, $urandom(), 6'($urandom_range(63, 16)),
                          5'($urandom_range(31)), 6'($urandom_range(63)));
            end else if (sel < 88) begin
                clock_ms = clock_ms + $urandom_range(400);
                send_item(KIND_TICK, clock_ms, 6'($urandom()), 5'($urandom()),
                          6'($urandom()));
            end else if (sel < 92) begin
                clock_ms = clock_ms + $urandom_range(20000);
                send_item(KIND_TICK, clock_ms, 6'($urandom()), 5'($urandom()),
                          6'($urandom()));
            end else if (sel < 94) begin
                send_item(KIND_TICK, $urandom(), 6'($urandom()), 5'($urandom()),
                          6'($urandom()));
            end else if (sel < 97) begin
                clock_ms = ($urandom_range(1)) ? $urandom() : $urandom_range(5000);
                send_item(KIND_INIT, clock_ms, 6'($urandom()), 5'($urandom()),
                          6'($urandom()));
            end else begin
                send_item(KIND_SPARE, $urandom(), 6'($urandom()), 5'($urandom()),
                          6'($urandom()));
            end
            i++;
        end

        drain_wakes();
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
